/* hdl/qth_pkg.sv */
`default_nettype none

package qth_pkg;

    localparam int MAX_BUCKETS_DEF = 256;
    localparam int WAYS_DEF        = 8;

    localparam int KEY_W   = 31;
    localparam int VALUE_W = 64;
    localparam int CFG_W   = 9;
    localparam int REM_W   = 9;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [1:0]         status;
    } out_t;

    typedef struct packed {
        logic [KEY_W-1:0]   tag;
        logic [VALUE_W-1:0] value;
    } entry_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_FILL,
        S_FILLW,
        S_RDE,
        S_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic clr_step;
        logic div_step;
        logic fill_rd;
        logic fill_act;
        logic ent_rd;
        logic chk_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic scan_go;
        logic scan_last;
        logic out_free;
    } sts_t;

    // Saturate a written bucket count into the range 1 to max_buckets.
    function automatic logic [CFG_W-1:0] clamp_count(input logic [CFG_W-1:0] raw,
                                                     input int max_buckets);
        logic [CFG_W-1:0] res;
        if (raw == '0)
            res = CFG_W'(1);
        else if (int'(raw) > max_buckets)
            res = CFG_W'(max_buckets);
        else
            res = raw;
        return res;
    endfunction

endpackage

`default_nettype wire

/* hdl/qth_ctrl.sv */
`default_nettype none

module qth_ctrl
    import qth_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (sts.clr_last) state_next = S_IDLE;
            S_IDLE:  if (in_valid) state_next = S_DIV;
            S_DIV:   if (sts.div_last) state_next = S_FILL;
            S_FILL:  state_next = S_FILLW;
            S_FILLW: state_next = sts.scan_go ? S_RDE : S_DONE;
            S_RDE:   state_next = S_CHK;
            S_CHK:   state_next = sts.scan_last ? S_DONE : S_RDE;
            S_DONE:  if (sts.out_free) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_CLEAR: cmd.clr_step = 1'b1;
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            S_DIV:   cmd.div_step = 1'b1;
            S_FILL:  cmd.fill_rd = 1'b1;
            S_FILLW: cmd.fill_act = 1'b1;
            S_RDE:   cmd.ent_rd = 1'b1;
            S_CHK:   cmd.chk_step = 1'b1;
            S_DONE:  cmd.out_load = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/qth_dpath.sv */
`default_nettype none

module qth_dpath
    import qth_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int WAYS        = WAYS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire in_t              in_data,
    input  wire logic             cfg_valid,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             out_stall,
    output logic                  out_valid,
    output out_t                  out_data,
    input  wire cmd_t             cmd,
    output sts_t                  sts
);

    localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int IW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FW    = $clog2(WAYS + 1);
    localparam int DEPTH = MAX_BUCKETS * WAYS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DCW   = $clog2(KEY_W);

    logic [CFG_W-1:0]   count_reg;
    logic [1:0]         op_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [KEY_W-1:0]   quo_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [DCW-1:0]     div_cnt_reg;
    logic [BW-1:0]      clr_cnt_reg;
    logic [FW-1:0]      fill_reg;
    logic [IW-1:0]      idx_reg;
    logic               found_reg;
    logic [VALUE_W-1:0] rv_reg;
    logic [1:0]         st_reg;
    logic               out_valid_reg;
    out_t               out_reg;

    entry_t             ent_mem [DEPTH];
    logic [FW-1:0]      fill_mem [MAX_BUCKETS];
    entry_t             ent_q;
    logic [FW-1:0]      fill_q;

    logic [REM_W:0]     div_sh;
    logic               div_ge;
    logic [BW-1:0]      bucket;
    logic [AW-1:0]      base;
    logic               ins_ok;
    logic               match;
    logic               del_done;
    logic               ent_we;
    logic [AW-1:0]      ent_waddr;
    entry_t             ent_wdata;
    logic               fill_we;
    logic [BW-1:0]      fill_waddr;
    logic [FW-1:0]      fill_wdata;

    assign div_sh   = {rem_reg, quo_reg[KEY_W-1]};
    assign div_ge   = div_sh >= {1'b0, count_reg};
    assign bucket   = BW'(rem_reg);
    assign base     = AW'(AW'(bucket) * AW'(WAYS));
    assign ins_ok   = fill_q != FW'(WAYS);
    assign match    = ent_q.tag == quo_reg;
    assign del_done = found_reg || match;

    assign sts.clr_last  = clr_cnt_reg == BW'(MAX_BUCKETS - 1);
    assign sts.div_last  = div_cnt_reg == DCW'(KEY_W - 1);
    assign sts.scan_go   = (op_reg == OP_READ || op_reg == OP_DELETE) && fill_q != '0;
    assign sts.scan_last = (FW'(idx_reg) + FW'(1)) == fill_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        ent_we     = 1'b0;
        ent_waddr  = base + AW'(fill_q);
        ent_wdata  = '{tag: quo_reg, value: val_reg};
        fill_we    = 1'b0;
        fill_waddr = bucket;
        fill_wdata = fill_q + FW'(1);
        if (cmd.clr_step)
        begin
            fill_we    = 1'b1;
            fill_waddr = clr_cnt_reg;
            fill_wdata = '0;
        end
        else if (cmd.fill_act && op_reg == OP_INSERT && ins_ok)
        begin
            ent_we  = 1'b1;
            fill_we = 1'b1;
        end
        else if (cmd.chk_step && op_reg == OP_DELETE)
        begin
            // Once the match is found, each later entry moves down one way.
            ent_we     = found_reg;
            ent_waddr  = base + AW'(idx_reg) - AW'(1);
            ent_wdata  = ent_q;
            fill_we    = sts.scan_last && del_done;
            fill_wdata = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_waddr] <= ent_wdata;
        if (cmd.ent_rd)
            ent_q <= ent_mem[base + AW'(idx_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
            fill_mem[fill_waddr] <= fill_wdata;
        if (cmd.fill_rd)
            fill_q <= fill_mem[bucket];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= clamp_count(CFG_W'(256), MAX_BUCKETS);
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                count_reg <= clamp_count(cfg_data, MAX_BUCKETS);
            if (cmd.clr_step)
                clr_cnt_reg <= clr_cnt_reg + BW'(1);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg      <= in_data.op;
            val_reg     <= in_data.value;
            quo_reg     <= in_data.key;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
            rv_reg      <= '0;
            st_reg      <= ST_MISS;
        end
        if (cmd.div_step)
        begin
            rem_reg     <= div_ge ? REM_W'(div_sh - {1'b0, count_reg}) : REM_W'(div_sh);
            quo_reg     <= {quo_reg[KEY_W-2:0], div_ge};
            div_cnt_reg <= div_cnt_reg + DCW'(1);
        end
        if (cmd.fill_act)
        begin
            fill_reg  <= fill_q;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            if (op_reg == OP_INSERT)
                st_reg <= ins_ok ? ST_OK : ST_FULL;
        end
        if (cmd.chk_step)
        begin
            idx_reg <= idx_reg + IW'(1);
            if (op_reg == OP_READ && match)
            begin
                rv_reg <= ent_q.value;
                st_reg <= ST_OK;
            end
            if (op_reg == OP_DELETE && !found_reg && match)
            begin
                found_reg <= 1'b1;
                st_reg    <= ST_OK;
            end
        end
        if (cmd.out_load)
            out_reg <= '{read_value: rv_reg, status: st_reg};
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

/* hdl/quotient_tag_hash_table.sv */
// Each word passes through the input load, the 31-step restoring divider and
// the fill read; a read or delete on a non-empty bucket then scans the bucket,
// reading and checking one way at a time, before the result is loaded into the
// output register. A new word is taken only once that result has been loaded.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the bucket
// fill counts before the first input word is taken.
`default_nettype none

module quotient_tag_hash_table
    import qth_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int WAYS        = WAYS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire in_t              in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_t                  out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data
);

    // The controller sequences each word: divide the key by the bucket count,
    // read the bucket fill, then append, or scan the bucket one way at a time.
    // The datapath holds the divider, the entry and fill memories and the
    // result register, which lets a new word enter while a result waits.
    cmd_t cmd;
    sts_t sts;

    // The bucket count register accepts a write on any cycle.
    assign cfg_ready = 1'b1;

    qth_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    qth_dpath #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .WAYS        (WAYS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire
